>>> sv/tvna_pkg.sv
// shared types and constants for the two-voice note allocator
// no dependencies
`timescale 1ns / 1ps

package tvna_pkg;

    localparam int NOTE_W   = 7;
    localparam int BEND_W   = 14;
    localparam int DATA_W   = 12;
    localparam int WORD_W   = 16;
    localparam int SCALE_W  = 4;
    localparam int CFG_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int OFFS_W   = 10;
    localparam int QUOT_W   = 6;

    localparam int BIT_CHAN   = 15;
    localparam int BIT_BUF    = 14;
    localparam int BIT_GAIN   = 13;
    localparam int BIT_ACTIVE = 12;

    localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
    localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
    localparam logic [1:0] CMD_BEND     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RETRIGGER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SECOND
    } state_t;

    typedef enum logic [2:0] {
        SEL_ZERO_OLDEST,
        SEL_NOTE_NEW,
        SEL_ZERO_FOUND,
        SEL_BEND_NEWEST,
        SEL_BEND_OLDEST
    } word_sel_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        word_sel_t sel;
        logic      first;
        logic      last;
        logic      commit;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       busy0;
        logic       busy1;
        logic       match;
    } status_t;

endpackage

>>> sv/tvna_ctrl.sv
// sequencer for the note allocator: decides which words an event emits
// depends on tvna_pkg
`timescale 1ns / 1ps

module tvna_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tvna_pkg::status_t status,
    output tvna_pkg::ctrl_t   ctrl
);
    import tvna_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ctrl.load   = 1'b0;
        ctrl.emit   = 1'b0;
        ctrl.sel    = SEL_NOTE_NEW;
        ctrl.first  = 1'b0;
        ctrl.last   = 1'b0;
        ctrl.commit = 1'b0;
        busy        = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                priority case (status.cmd)
                    CMD_NOTE_ON:
                    begin
                        ctrl.emit  = 1'b1;
                        ctrl.first = 1'b1;
                        if (status.busy1)
                        begin
                            // steal: silence the oldest channel first
                            ctrl.sel   = SEL_ZERO_OLDEST;
                            state_next = ST_SECOND;
                        end
                        else
                        begin
                            ctrl.sel    = SEL_NOTE_NEW;
                            ctrl.last   = 1'b1;
                            ctrl.commit = 1'b1;
                        end
                    end
                    CMD_NOTE_OFF:
                    begin
                        if (status.match)
                        begin
                            ctrl.emit   = 1'b1;
                            ctrl.sel    = SEL_ZERO_FOUND;
                            ctrl.last   = 1'b1;
                            ctrl.commit = 1'b1;
                        end
                    end
                    CMD_BEND:
                    begin
                        if (status.busy0)
                        begin
                            ctrl.emit = 1'b1;
                            ctrl.sel  = SEL_BEND_NEWEST;
                            if (status.busy1)
                            begin
                                state_next = ST_SECOND;
                            end
                            else
                            begin
                                ctrl.last = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SECOND:
            begin
                state_next  = ST_IDLE;
                ctrl.emit   = 1'b1;
                ctrl.last   = 1'b1;
                ctrl.commit = 1'b1;
                if (status.cmd == CMD_BEND)
                begin
                    ctrl.sel = SEL_BEND_OLDEST;
                end
                else
                begin
                    ctrl.sel = SEL_NOTE_NEW;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/tvna_datapath.sv
// voice slots, config registers, word formatting and output register
// depends on tvna_pkg
`timescale 1ns / 1ps

module tvna_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    command,
    input  logic [tvna_pkg::NOTE_W-1:0]   note,
    input  logic signed [tvna_pkg::BEND_W-1:0] bend,
    input  logic                          cfg_write,
    input  logic [tvna_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tvna_pkg::CFG_W-1:0]    cfg_data,
    input  tvna_pkg::ctrl_t               ctrl,
    output tvna_pkg::status_t             status,
    output logic                          strobe,
    output logic [tvna_pkg::WORD_W-1:0]   dac_word,
    output logic                          gate_level,
    output logic                          gate_retrigger,
    output logic                          last
);
    import tvna_pkg::*;

    // config
    logic               retrig_en_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic               buf_bit_reg;
    logic               gain_bit_reg;

    // latched event
    logic [1:0]               cmd_reg;
    logic [NOTE_W-1:0]        note_reg;
    logic signed [BEND_W-1:0] bend_reg;

    // voice slots, 0 newest
    logic [NOTE_W-1:0] note0_reg, note1_reg;
    logic              busy0_reg, busy1_reg;
    logic              dac0_reg, dac1_reg;
    logic              gate_reg;

    logic              strobe_reg;
    logic [WORD_W-1:0] word_reg;
    logic              gate_out_reg;
    logic              retrig_out_reg;
    logic              last_reg;

    logic              match0;
    logic              match1;
    logic              ch_new;
    logic              gate_next;
    logic signed [QUOT_W-1:0] quot;
    logic signed [OFFS_W-1:0] offs;
    logic [DATA_W-1:0] note_data;
    logic [DATA_W-1:0] bend0_data;
    logic [DATA_W-1:0] bend1_data;
    logic              sel_chan;
    logic [DATA_W-1:0] sel_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retrig_en_reg <= 1'b1;
            scale_reg     <= SCALE_W'(1);
            buf_bit_reg   <= 1'b0;
            gain_bit_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RETRIGGER: retrig_en_reg <= cfg_data[0];
                REG_SCALE:     scale_reg     <= cfg_data[SCALE_W-1:0];
                REG_BUFFER:    buf_bit_reg   <= cfg_data[0];
                REG_GAIN:      gain_bit_reg  <= cfg_data[0];
                default:       retrig_en_reg <= retrig_en_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= command;
            note_reg <= note;
            bend_reg <= bend;
        end
    end

    assign match0 = busy0_reg && (note0_reg == note_reg);
    assign match1 = busy1_reg && (note1_reg == note_reg);

    assign status.cmd   = cmd_reg;
    assign status.busy0 = busy0_reg;
    assign status.busy1 = busy1_reg;
    assign status.match = match0 || match1;

    always_comb
    begin
        priority if (busy1_reg)
        begin
            ch_new = dac1_reg;
        end
        else if (busy0_reg)
        begin
            ch_new = ~dac0_reg;
        end
        else
        begin
            ch_new = 1'b0;
        end
    end

    // bend / 256 truncated toward zero
    assign quot = bend_reg[BEND_W-1:BEND_W-QUOT_W]
                + QUOT_W'((bend_reg[BEND_W-1] && (bend_reg[7:0] != 8'd0)) ? 1 : 0);
    assign offs = $signed({1'b0, scale_reg}) * quot;

    assign note_data  = {note_reg, 5'd0};
    assign bend0_data = {note0_reg, 5'd0} + DATA_W'(offs);
    assign bend1_data = {note1_reg, 5'd0} + DATA_W'(offs);

    always_comb
    begin
        unique case (cmd_reg)
            CMD_NOTE_ON:  gate_next = 1'b1;
            CMD_NOTE_OFF: gate_next = busy1_reg ? gate_reg : 1'b0;
            default:      gate_next = gate_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.sel)
            SEL_ZERO_OLDEST:
            begin
                sel_chan = dac1_reg;
                sel_data = '0;
            end
            SEL_NOTE_NEW:
            begin
                sel_chan = ch_new;
                sel_data = note_data;
            end
            SEL_ZERO_FOUND:
            begin
                sel_chan = match0 ? dac0_reg : dac1_reg;
                sel_data = '0;
            end
            SEL_BEND_NEWEST:
            begin
                sel_chan = dac0_reg;
                sel_data = bend0_data;
            end
            SEL_BEND_OLDEST:
            begin
                sel_chan = dac1_reg;
                sel_data = bend1_data;
            end
            default:
            begin
                sel_chan = 1'b0;
                sel_data = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note0_reg <= '0;
            note1_reg <= '0;
            busy0_reg <= 1'b0;
            busy1_reg <= 1'b0;
            dac0_reg  <= 1'b0;
            dac1_reg  <= 1'b0;
            gate_reg  <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            gate_reg <= gate_next;
            if (cmd_reg == CMD_NOTE_ON)
            begin
                note1_reg <= note0_reg;
                busy1_reg <= busy0_reg;
                dac1_reg  <= dac0_reg;
                note0_reg <= note_reg;
                busy0_reg <= 1'b1;
                dac0_reg  <= ch_new;
            end
            else if (cmd_reg == CMD_NOTE_OFF)
            begin
                // releasing the newest closes up the oldest into its place
                if (match0)
                begin
                    note0_reg <= note1_reg;
                    busy0_reg <= busy1_reg;
                    dac0_reg  <= dac1_reg;
                end
                note1_reg <= '0;
                busy1_reg <= 1'b0;
                dac1_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctrl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            word_reg       <= {sel_chan, buf_bit_reg, gain_bit_reg, 1'b1, sel_data};
            gate_out_reg   <= gate_next;
            retrig_out_reg <= ctrl.first && (!busy0_reg || retrig_en_reg);
            last_reg       <= ctrl.last;
        end
    end

    assign strobe         = strobe_reg;
    assign dac_word       = word_reg;
    assign gate_level     = gate_out_reg;
    assign gate_retrigger = retrig_out_reg;
    assign last           = last_reg;

endmodule

>>> sv/two_voice_note_allocator.sv
// two-voice note allocator, oldest note stolen when both voices are held
// an event is latched in ST_IDLE and decided in ST_EXEC, and a second word
// (steal or two-voice bend) is formed in ST_SECOND, as set by the sequencer;
// each word is registered and shows on the outputs in the cycle after it is formed
// busy stays high until the last word is formed; results cannot be stalled
// reset clears the voices, the gate and the config to its defaults
`timescale 1ns / 1ps

module two_voice_note_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    command,
    input  logic [tvna_pkg::NOTE_W-1:0]   note,
    input  logic signed [tvna_pkg::BEND_W-1:0] bend,
    input  logic                          cfg_write,
    input  logic [tvna_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tvna_pkg::CFG_W-1:0]    cfg_data,
    output logic                          strobe,
    output logic [tvna_pkg::WORD_W-1:0]   dac_word,
    output logic                          gate_level,
    output logic                          gate_retrigger,
    output logic                          last
);
    import tvna_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    tvna_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .ctrl   (ctrl)
    );

    tvna_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .command        (command),
        .note           (note),
        .bend           (bend),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .ctrl           (ctrl),
        .status         (status),
        .strobe         (strobe),
        .dac_word       (dac_word),
        .gate_level     (gate_level),
        .gate_retrigger (gate_retrigger),
        .last           (last)
    );

endmodule

>>> dv/two_voice_note_allocator_tb.sv
// self-checking testbench for two_voice_note_allocator: directed and random midi events
// a scoreboard class predicts every dac word; depends on tvna_pkg and the block
`timescale 1ns / 1ps

module two_voice_note_allocator_tb;

    import tvna_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int NOTE_STEP  = 32;
    localparam int BEND_DIV   = 256;
    localparam int IDLE_LIMIT = 1000;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              gate_on;
        logic              retrig;
        logic              last_flag;
    } dac_cmd_t;

    class note_alloc_scoreboard;
        logic [NOTE_W-1:0] voice_note[2];
        logic              voice_busy[2];
        logic              voice_chan[2];
        int                held;
        logic              gate_on;
        logic              retrig_en;
        logic [CFG_W-1:0]  bend_scale;
        logic              buffer_bit;
        logic              gain_bit;
        int                errors;
        dac_cmd_t          expected_q[$];

        function new();
            for (int i = 0; i < 2; i++) begin
                voice_note[i] = '0;
                voice_busy[i] = 1'b0;
                voice_chan[i] = 1'b0;
            end
            held       = 0;
            gate_on    = 1'b0;
            retrig_en  = 1'b1;
            bend_scale = 4'd1;
            buffer_bit = 1'b0;
            gain_bit   = 1'b0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_RETRIGGER: retrig_en = data[0];
                REG_SCALE:     bend_scale = data;
                REG_BUFFER:    buffer_bit = data[0];
                REG_GAIN:      gain_bit = data[0];
                default:       ;
            endcase
        endfunction

        function void push_word(logic chan, int data, logic retrig, logic last_flag);
            dac_cmd_t c;
            c.word = '0;
            c.word[DATA_W-1:0] = data[DATA_W-1:0];
            c.word[BIT_CHAN]   = chan;
            c.word[BIT_BUF]    = buffer_bit;
            c.word[BIT_GAIN]   = gain_bit;
            c.word[BIT_ACTIVE] = 1'b1;
            c.gate_on   = gate_on;
            c.retrig    = retrig;
            c.last_flag = last_flag;
            expected_q.push_back(c);
        endfunction

        // works out the words one accepted event causes and updates the voices
        function void note_input(logic [1:0] cmd, logic [NOTE_W-1:0] nt,
                                 logic signed [BEND_W-1:0] bd);
            logic retrig;
            logic ch;
            int   found;
            int   offs;
            int   total;
            int   n;
            case (cmd)
                CMD_NOTE_ON: begin
                    retrig  = (held == 0) || retrig_en;
                    gate_on = 1'b1;
                    if (voice_busy[1]) begin
                        // steal the oldest voice: silence its channel first
                        ch = voice_chan[1];
                        push_word(ch, 0, retrig, 1'b0);
                        push_word(ch, int'(nt) * NOTE_STEP, 1'b0, 1'b1);
                        voice_note[1] = voice_note[0];
                        voice_busy[1] = voice_busy[0];
                        voice_chan[1] = voice_chan[0];
                        voice_chan[0] = ch;
                    end else if (voice_busy[0]) begin
                        ch = ~voice_chan[0];
                        push_word(ch, int'(nt) * NOTE_STEP, retrig, 1'b1);
                        voice_note[1] = voice_note[0];
                        voice_busy[1] = 1'b1;
                        voice_chan[1] = voice_chan[0];
                        voice_chan[0] = ch;
                    end else begin
                        push_word(1'b0, int'(nt) * NOTE_STEP, retrig, 1'b1);
                        voice_chan[0] = 1'b0;
                    end
                    voice_note[0] = nt;
                    voice_busy[0] = 1'b1;
                    held = voice_busy[1] ? 2 : 1;
                end
                CMD_NOTE_OFF: begin
                    found = -1;
                    for (int i = 1; i >= 0; i--)
                        if (voice_busy[i] && voice_note[i] == nt)
                            found = i;
                    if (found >= 0) begin
                        ch = voice_chan[found];
                        if (found == 0) begin
                            voice_note[0] = voice_note[1];
                            voice_busy[0] = voice_busy[1];
                            voice_chan[0] = voice_chan[1];
                        end
                        voice_note[1] = '0;
                        voice_busy[1] = 1'b0;
                        voice_chan[1] = 1'b0;
                        held = held - 1;
                        if (held == 0)
                            gate_on = 1'b0;
                        push_word(ch, 0, 1'b0, 1'b1);
                    end
                end
                CMD_BEND: begin
                    // division truncates toward zero
                    offs  = int'(bend_scale) * (int'(bd) / BEND_DIV);
                    total = int'(voice_busy[0]) + int'(voice_busy[1]);
                    n = 0;
                    for (int i = 0; i < 2; i++) begin
                        if (voice_busy[i]) begin
                            n++;
                            push_word(voice_chan[i], int'(voice_note[i]) * NOTE_STEP + offs,
                                      1'b0, n == total);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [WORD_W-1:0] w, logic g, logic r, logic l);
            dac_cmd_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected word %h", w));
                return;
            end
            e = expected_q.pop_front();
            if (w !== e.word)
                report($sformatf("dac_word %h, wanted %h", w, e.word));
            if (g !== e.gate_on)
                report($sformatf("gate_level %b, wanted %b", g, e.gate_on));
            if (r !== e.retrig)
                report($sformatf("gate_retrigger %b, wanted %b", r, e.retrig));
            if (l !== e.last_flag)
                report($sformatf("last %b, wanted %b", l, e.last_flag));
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                command;
    logic [NOTE_W-1:0]         note;
    logic signed [BEND_W-1:0]  bend;
    logic                      cfg_write;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      strobe;
    logic [WORD_W-1:0]         dac_word;
    logic                      gate_level;
    logic                      gate_retrigger;
    logic                      last;

    note_alloc_scoreboard sb;
    int idle_cycles;

    two_voice_note_allocator DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .note           (note),
        .bend           (bend),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .strobe         (strobe),
        .dac_word       (dac_word),
        .gate_level     (gate_level),
        .gate_retrigger (gate_retrigger),
        .last           (last)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // a finishing word may land on the same edge as the next event
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (strobe)
                sb.check_result(dac_word, gate_level, gate_retrigger, last);
            if (start && !busy)
                sb.note_input(command, note, bend);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [NOTE_W-1:0] nt,
                             input logic signed [BEND_W-1:0] bd, input int gap_pct,
                             input bit hold);
        int n;
        n = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 6) : 0;
        repeat (n) @(negedge clk) start <= 1'b0;
        if (hold) begin
            @(negedge clk) start <= 1'b0;
            while (sb.pending() != 0)
                @(negedge clk) start <= 1'b0;
        end
        @(negedge clk);
        start   <= 1'b1;
        command <= cmd;
        note    <= nt;
        bend    <= bd;
        do @(posedge clk); while (busy);
    endtask

    // let the block finish, including events that make no word
    task automatic settle();
        @(negedge clk) start <= 1'b0;
        while (sb.pending() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_registers(input logic retrig, input logic [CFG_W-1:0] scale,
                                     input logic buffer_b, input logic gain_b);
        logic [CFG_W-1:0] vals[4];
        vals[REG_RETRIGGER] = {3'($urandom), retrig};
        vals[REG_SCALE]     = scale;
        vals[REG_BUFFER]    = {3'($urandom), buffer_b};
        vals[REG_GAIN]      = {3'($urandom), gain_b};
        for (int k = 0; k < 4; k++) begin
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_index <= CFG_IDX_W'(k);
            cfg_data  <= vals[k];
            sb.set_reg(CFG_IDX_W'(k), vals[k]);
        end
        @(negedge clk) cfg_write <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int gap_pct);
        logic [1:0]               cmd;
        logic [NOTE_W-1:0]        nt;
        logic signed [BEND_W-1:0] bd;
        int                       r;
        for (int i = 0; i < count; i++) begin
            r  = $urandom_range(0, 99);
            nt = ($urandom_range(0, 3) == 0) ? NOTE_W'($urandom_range(0, 127))
                                             : NOTE_W'($urandom_range(58, 65));
            bd = BEND_W'($urandom_range(0, 16383));
            if ($urandom_range(0, 9) == 0)
                bd = $urandom_range(0, 1) ? 14'sh1fff : 14'sh2000;
            if (r < 38) begin
                cmd = CMD_NOTE_ON;
            end else if (r < 73) begin
                cmd = CMD_NOTE_OFF;
                // mostly release a note that is held
                if (sb.held > 0 && $urandom_range(0, 9) < 7)
                    nt = sb.voice_note[$urandom_range(0, sb.held - 1)];
            end else if (r < 95) begin
                cmd = CMD_BEND;
            end else begin
                cmd = CMD_UNUSED;
            end
            send_item(cmd, nt, bd, gap_pct, i == 0 || $urandom_range(0, 99) < 3);
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] scales[8];
        int               gaps[8];
        sb = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        command   = CMD_NOTE_ON;
        note      = '0;
        bend      = '0;
        cfg_write = 1'b0;
        cfg_index = REG_RETRIGGER;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // reset settings: nothing held, then fill, steal and release
        send_item(CMD_NOTE_OFF, 7'd5, 14'sd0, 0, 0);
        send_item(CMD_BEND, 7'd0, 14'sd100, 0, 0);
        send_item(CMD_UNUSED, 7'd127, 14'sh1fff, 0, 0);
        send_item(CMD_NOTE_ON, 7'd0, 14'sd0, 0, 0);
        send_item(CMD_NOTE_ON, 7'd127, 14'sd0, 0, 0);
        send_item(CMD_BEND, 7'd0, 14'sh1fff, 0, 0);
        send_item(CMD_BEND, 7'd0, 14'sh2000, 0, 0);
        send_item(CMD_NOTE_ON, 7'd60, 14'sd0, 0, 0);
        send_item(CMD_NOTE_OFF, 7'd99, 14'sd0, 0, 0);
        send_item(CMD_NOTE_OFF, 7'd60, 14'sd0, 0, 0);
        send_item(CMD_NOTE_ON, 7'd127, 14'sd0, 0, 0);
        // same note in both voices: the newer one goes
        send_item(CMD_NOTE_OFF, 7'd127, 14'sd0, 0, 0);
        send_item(CMD_BEND, 7'd0, -14'sd1, 0, 0);
        send_item(CMD_BEND, 7'd0, 14'sd255, 0, 0);
        send_item(CMD_BEND, 7'd0, -14'sd256, 0, 0);
        send_item(CMD_NOTE_OFF, 7'd127, 14'sd0, 0, 0);
        settle();

        // no retrigger, widest scale, both control bits set
        program_registers(1'b0, 4'd15, 1'b1, 1'b1);
        send_item(CMD_NOTE_ON, 7'd10, 14'sd0, 0, 0);
        send_item(CMD_NOTE_ON, 7'd20, 14'sd0, 0, 0);
        send_item(CMD_NOTE_ON, 7'd30, 14'sd0, 0, 0);
        send_item(CMD_BEND, 7'd0, 14'sh2000, 0, 0);
        send_item(CMD_BEND, 7'd0, 14'sh1fff, 0, 0);
        send_item(CMD_NOTE_OFF, 7'd20, 14'sd0, 0, 0);
        send_item(CMD_NOTE_OFF, 7'd30, 14'sd0, 0, 0);
        settle();

        scales = '{4'd1, 4'd12, 4'd0, 4'd15, 4'd13, 4'd7, 4'd12, 4'd0};
        gaps   = '{0, 78, 8, 0, 78, 8, 0, 78};
        for (int p = 0; p < 8; p++) begin
            program_registers(p[0] == 0, scales[p], p[1], p[2]);
            run_phase(160, gaps[p]);
            settle();
        end

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> two_voice_note_allocator.f
sv/tvna_pkg.sv
sv/tvna_ctrl.sv
sv/tvna_datapath.sv
sv/two_voice_note_allocator.sv
dv/two_voice_note_allocator_tb.sv
